@@ hw/rtl/emic_pkg.sv @@
// Package for the environment map importance CDF block.
// Holds the sequencer state type, command and register codes and fixed-point constants.
// Depends on nothing; imported by env_map_importance_cdf.
`timescale 1ns / 1ps
`default_nettype none

package emic_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L_M0,
    ST_L_M1,
    ST_L_M2,
    ST_L_M3,
    ST_L_WT,
    ST_L_WT2,
    ST_L_STORE,
    ST_S_T,
    ST_S_U,
    ST_S_X,
    ST_S_X2,
    ST_S_F,
    ST_S_TM,
    ST_S_Q,
    ST_R_RD,
    ST_R_LAT,
    ST_R_N,
    ST_R_NC,
    ST_R_SC,
    ST_R_SCW,
    ST_R_MW,
    ST_R_COND,
    ST_R_CW,
    ST_R_PDF,
    ST_R_RW,
    ST_R_P1,
    ST_R_P2,
    ST_R_P3,
    ST_R_OUT,
    ST_DIV
  } state_e;

  // Input word kinds.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EARLY = 1'b1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUAL  = 2'd2;

  // Rec.709 luminance weights in Q0.16; they add up to exactly one.
  localparam logic [31:0] LUM_R = 32'd13933;
  localparam logic [31:0] LUM_G = 32'd46871;
  localparam logic [31:0] LUM_B = 32'd4732;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  // 1/(2*pi^2) and 1/(4*pi) in Q0.32.
  localparam logic [31:0] INV_2PI2_Q32 = 32'd217585585;
  localparam logic [31:0] INV_4PI_Q32  = 32'd341782637;

  // Divisors of the Horner steps of the sine series, innermost first.
  function automatic logic [6:0] taylor_div(input logic [2:0] idx);
    logic [6:0] d;
    case (idx)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/env_map_importance_cdf.sv @@
// Top level of the environment map importance CDF block.
// Contains the sequencer, the shared multiplier and divider and the weight memories.
// Depends on emic_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes the pixels of an HDR environment map in row-major order and
// then hands back, pixel by pixel, the tables used for importance sampling.
// A word with tuser 0 loads the next pixel (RGB in unsigned Q16.16); its weight
// is the Rec.709 luminance times the sine of the row's polar angle (or just
// the luminance in equal-area mode), stored in an internal memory together
// with per-row sums and the image total. A load produces no result word. Once
// the whole image is in, a word with tuser 1 returns the next pixel's
// conditional row CDF (Q0.16), its PDF (Q16.16, saturating) and, at column 0,
// the marginal CDF through that row; the read position wraps after the last
// pixel, which is flagged by tlast. A read before the image is complete gives
// one word with tuser 1 and all data zero. Loading after the image is complete
// starts a new image, as does a write to the width, height or equal-area
// configuration register. All arithmetic runs on one 32x32 multiplier and
// one restoring divider that retires one quotient bit per cycle, under a
// small sequencer; the block takes no new word while it works. The time of a
// read is set mostly by the 16-bit and 32-bit divisions of the CDF and PDF.
// The first pixel of each row costs extra: the sine (six 32-bit divisions) in
// sine mode, and on reads the per-row PDF scale (a 64-bit division) and the
// marginal CDF. The memories need no clearing pass.
module env_map_importance_cdf
  #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 512
  )
  (
    input  wire logic                             clk_i,
    input  wire logic                             rst_ni,
    // configuration
    input  wire logic                             cfg_we_i,
    input  wire logic [emic_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
    input  wire logic [emic_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
    // input words
    input  wire logic                             s_axis_tvalid_i,
    output logic                                  s_axis_tready_o,
    input  wire logic [95:0]                      s_axis_tdata_i,  // red, green, blue
    input  wire logic                             s_axis_tuser_i,  // cmd
    // result words
    output logic                                  m_axis_tvalid_o,
    input  wire logic                             m_axis_tready_i,
    output logic [87:0]                           m_axis_tdata_o,  // cond_cdf, marginal_cdf,
                                                                   // pdf_value, pixel_col,
                                                                   // pixel_row, zero fill
    output logic                                  m_axis_tlast_o,  // last_result
    output logic                                  m_axis_tuser_o   // status
  );

  import emic_pkg::*;

  localparam int unsigned PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned POS_W     = $clog2(PIX_DEPTH);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned WU_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HU_W      = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RS_W      = 32 + COL_W;
  localparam int unsigned GT_W      = 32 + POS_W;
  localparam int unsigned RW        = GT_W;

  // Configuration and the geometry actually in use.
  logic [10:0]     cfg_w_q;
  logic [9:0]      cfg_h_q;
  logic            cfg_eq_q;
  logic [WU_W-1:0] wu;
  logic [HU_W-1:0] hu;
  logic            cfg_hit;

  assign wu = (cfg_w_q == '0) ? WU_W'(1) :
              ((32'(cfg_w_q) > MAX_WIDTH) ? WU_W'(MAX_WIDTH) : WU_W'(cfg_w_q));
  assign hu = (cfg_h_q == '0) ? HU_W'(1) :
              ((32'(cfg_h_q) > MAX_HEIGHT) ? HU_W'(MAX_HEIGHT) : HU_W'(cfg_h_q));
  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT ||
                    cfg_idx_i == CFG_EQUAL);

  // Sequencer and positions.
  state_e          state_q, state_d, div_ret_q, div_ret_d;
  logic            phase_q;  // set once the image is complete
  logic [POS_W-1:0] lpos_q, rpos_q;
  logic [COL_W-1:0] lcol_q, rcol_q;
  logic [ROW_W-1:0] lrow_q, rrow_q;
  logic [GT_W-1:0]  gt_q;
  logic             out_valid_q;

  logic in_acc, out_free, restart, l_last, r_last;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign restart  = cfg_hit ||
                    (in_acc && s_axis_tuser_i == CMD_LOAD && phase_q);
  assign l_last = (lcol_q == COL_W'(wu - WU_W'(1))) && (lrow_q == ROW_W'(hu - HU_W'(1)));
  assign r_last = (rcol_q == COL_W'(wu - WU_W'(1))) && (rrow_q == ROW_W'(hu - HU_W'(1)));

  // Datapath registers.
  logic [31:0]     red_q, green_q, blue_q;
  logic [49:0]     acc_q;
  logic [31:0]     lum_q, weight_q;
  logic [RS_W-1:0] row_acc_q, row_acc_new;
  logic [31:0]     x_q, x2_q;
  logic [2:0]      ti_q;
  logic [16:0]     sine_q;
  logic            sine_rd_q;
  logic            err_q;
  logic [GT_W-1:0] marg_pre_q;
  logic [RS_W-1:0] row_pre_q, rp_new;
  logic [63:0]     scale_q;
  logic [16:0]     marg_q, cond_q;
  logic [32:0]     r32_q;
  logic [33:0]     t2_q;
  logic [31:0]     pdf_q;

  // Memories.
  logic [31:0]     wmem [PIX_DEPTH];
  logic [RS_W-1:0] rsmem [MAX_HEIGHT];
  logic [31:0]     w_rd_q;
  logic [RS_W-1:0] rs_rd_q;

  // Shared multiplier, registered product.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_q;

  // Shared restoring divider.
  logic          div_start;
  logic [63:0]   div_n_in;
  logic [RW-1:0] div_d_in, div_r0_in;
  logic [6:0]    div_k_in;
  logic [RW-1:0] div_r_q, div_d_q;
  logic [63:0]   div_n_q, div_q_q;
  logic [6:0]    div_cnt_q;
  logic [RW:0]   div_rem2;
  logic          div_ge, div_rnd;

  assign div_rem2 = {div_r_q, div_n_q[63]};
  assign div_ge   = div_rem2 >= {1'b0, div_d_q};
  assign div_rnd  = {div_r_q, 1'b0} >= {1'b0, div_d_q};

  // Values derived for the sequencer.
  logic [ROW_W-1:0] sine_row;
  logic [16:0]      t_val, u_val, s_div;
  logic [31:0]      x_now, x2_now, f_new;
  logic [17:0]      q_sine;
  logic [RW-1:0]    rp_ext, rs_ext, w_ext, mp_ext;
  logic [65:0]      p2_sum, p3_sum;

  assign sine_row = sine_rd_q ? rrow_q : lrow_q;
  assign t_val    = div_q_q[16:0];
  assign u_val    = (t_val <= 17'd32768) ? t_val :
                    ((t_val >= 17'd65536) ? 17'd0 : 17'd65536 - t_val);
  assign x_now    = 32'(mul_p_q >> 16);
  assign x2_now   = 32'(mul_p_q >> 30);
  assign f_new    = ONE_Q30 - div_q_q[31:0];
  assign q_sine   = 18'(((mul_p_q >> 30) + 64'd8192) >> 14);
  assign s_div    = cfg_eq_q ? 17'd65536 : ((sine_q == '0) ? 17'd1 : sine_q);
  assign row_acc_new = ((lcol_q == '0) ? '0 : row_acc_q) + RS_W'(weight_q);
  assign rp_new   = row_pre_q + RS_W'(w_rd_q);
  assign rp_ext   = RW'(rp_new);
  assign rs_ext   = RW'(rs_rd_q);
  assign w_ext    = RW'(w_rd_q);
  assign mp_ext   = marg_pre_q;
  assign p2_sum   = 66'(mul_p_q) + (r32_q[32] ? {2'b00, scale_q[31:0], 32'h0} : 66'h0)
                    + 66'h8000_0000;
  assign p3_sum   = 66'(mul_p_q) + (r32_q[32] ? {2'b00, scale_q[63:32], 32'h0} : 66'h0)
                    + 66'(t2_q);

  // Next state, multiplier operands and divider launches.
  always_comb begin
    state_d   = state_q;
    div_ret_d = div_ret_q;
    div_start = 1'b0;
    div_n_in  = '0;
    div_d_in  = '0;
    div_r0_in = '0;
    div_k_in  = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CMD_LOAD) state_d = ST_L_M0;
          else state_d = phase_q ? ST_R_RD : ST_R_OUT;
        end
      end
      ST_L_M0: begin
        mul_a = red_q; mul_b = LUM_R; state_d = ST_L_M1;
      end
      ST_L_M1: begin
        mul_a = green_q; mul_b = LUM_G; state_d = ST_L_M2;
      end
      ST_L_M2: begin
        mul_a = blue_q; mul_b = LUM_B; state_d = ST_L_M3;
      end
      ST_L_M3: begin
        state_d = (lcol_q == '0 && !cfg_eq_q) ? ST_S_T : ST_L_WT;
      end
      ST_L_WT: begin
        mul_a = lum_q; mul_b = 32'(sine_q);
        state_d = cfg_eq_q ? ST_L_STORE : ST_L_WT2;
      end
      ST_L_WT2:   state_d = ST_L_STORE;
      ST_L_STORE: state_d = ST_IDLE;
      ST_S_T: begin
        div_start = 1'b1;
        div_n_in  = 64'({sine_row, 1'b1}) << 48;
        div_d_in  = RW'({hu, 1'b0});
        div_k_in  = 7'd32;
        div_ret_d = ST_S_U;
        state_d   = ST_DIV;
      end
      ST_S_U: begin
        mul_a = 32'(u_val); mul_b = PI_Q30; state_d = ST_S_X;
      end
      ST_S_X: begin
        mul_a = x_now; mul_b = x_now; state_d = ST_S_X2;
      end
      ST_S_X2: begin
        div_start = 1'b1;
        div_n_in  = {x2_now, 32'h0};
        div_d_in  = RW'(taylor_div(3'd0));
        div_k_in  = 7'd32;
        div_ret_d = ST_S_F;
        state_d   = ST_DIV;
      end
      ST_S_F: begin
        mul_b = f_new;
        if (ti_q == 3'd4) begin
          mul_a = x_q; state_d = ST_S_Q;
        end else begin
          mul_a = x2_q; state_d = ST_S_TM;
        end
      end
      ST_S_TM: begin
        div_start = 1'b1;
        div_n_in  = {x2_now, 32'h0};
        div_d_in  = RW'(taylor_div(ti_q + 3'd1));
        div_k_in  = 7'd32;
        div_ret_d = ST_S_F;
        state_d   = ST_DIV;
      end
      ST_S_Q:   state_d = sine_rd_q ? ST_R_N : ST_L_WT;
      ST_R_RD:  state_d = ST_R_LAT;
      ST_R_LAT: begin
        if (rcol_q == '0) state_d = cfg_eq_q ? ST_R_N : ST_S_T;
        else state_d = ST_R_COND;
      end
      ST_R_N: begin
        mul_a = 32'(wu); mul_b = 32'(hu); state_d = ST_R_NC;
      end
      ST_R_NC: begin
        mul_a = mul_p_q[31:0];
        mul_b = cfg_eq_q ? INV_4PI_Q32 : INV_2PI2_Q32;
        state_d = ST_R_SC;
      end
      ST_R_SC: begin
        div_start = 1'b1;
        div_n_in  = mul_p_q + 64'(s_div >> 1);
        div_d_in  = RW'(s_div);
        div_k_in  = 7'd64;
        div_ret_d = ST_R_SCW;
        state_d   = ST_DIV;
      end
      ST_R_SCW: begin
        if (gt_q != '0) begin
          div_start = 1'b1;
          div_r0_in = (mp_ext > gt_q) ? gt_q : mp_ext;
          div_d_in  = gt_q;
          div_k_in  = 7'd16;
          div_ret_d = ST_R_MW;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_R_COND;
        end
      end
      ST_R_MW: state_d = ST_R_COND;
      ST_R_COND: begin
        if (rs_rd_q != '0) begin
          div_start = 1'b1;
          div_r0_in = (rp_ext > rs_ext) ? rs_ext : rp_ext;
          div_d_in  = rs_ext;
          div_k_in  = 7'd16;
          div_ret_d = ST_R_CW;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_R_PDF;
        end
      end
      ST_R_CW: state_d = ST_R_PDF;
      ST_R_PDF: begin
        if (gt_q != '0) begin
          div_start = 1'b1;
          div_r0_in = (w_ext > gt_q) ? gt_q : w_ext;
          div_d_in  = gt_q;
          div_k_in  = 7'd32;
          div_ret_d = ST_R_RW;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_R_OUT;
        end
      end
      ST_R_RW: state_d = ST_R_P1;
      ST_R_P1: begin
        mul_a = r32_q[31:0]; mul_b = scale_q[31:0]; state_d = ST_R_P2;
      end
      ST_R_P2: begin
        mul_a = r32_q[31:0]; mul_b = scale_q[63:32]; state_d = ST_R_P3;
      end
      ST_R_P3: state_d = ST_R_OUT;
      ST_R_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_cnt_q == '0) state_d = div_ret_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_ret_q   <= ST_IDLE;
      div_cnt_q   <= '0;
      cfg_w_q     <= 11'd1024;
      cfg_h_q     <= 10'd512;
      cfg_eq_q    <= 1'b0;
      phase_q     <= 1'b0;
      lpos_q      <= '0;
      lcol_q      <= '0;
      lrow_q      <= '0;
      rpos_q      <= '0;
      rcol_q      <= '0;
      rrow_q      <= '0;
      gt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_ret_q <= div_ret_d;
      if (div_start) div_cnt_q <= div_k_in;
      else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 7'd1;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  cfg_w_q  <= cfg_wdata_i;
          CFG_HEIGHT: cfg_h_q  <= cfg_wdata_i[9:0];
          CFG_EQUAL:  cfg_eq_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (restart) begin
        phase_q <= 1'b0;
        gt_q    <= '0;
        lpos_q  <= '0;
        lcol_q  <= '0;
        lrow_q  <= '0;
        rpos_q  <= '0;
        rcol_q  <= '0;
        rrow_q  <= '0;
      end else if (state_q == ST_L_STORE) begin
        gt_q   <= gt_q + GT_W'(weight_q);
        lpos_q <= lpos_q + POS_W'(1);
        if (lcol_q == COL_W'(wu - WU_W'(1))) begin
          lcol_q <= '0;
          lrow_q <= lrow_q + ROW_W'(1);
        end else begin
          lcol_q <= lcol_q + COL_W'(1);
        end
        if (l_last) begin
          phase_q <= 1'b1;
          rpos_q  <= '0;
          rcol_q  <= '0;
          rrow_q  <= '0;
        end
      end else if (state_q == ST_R_OUT && out_free && !err_q) begin
        if (r_last) begin
          rpos_q <= '0;
          rcol_q <= '0;
          rrow_q <= '0;
        end else begin
          rpos_q <= rpos_q + POS_W'(1);
          if (rcol_q == COL_W'(wu - WU_W'(1))) begin
            rcol_q <= '0;
            rrow_q <= rrow_q + ROW_W'(1);
          end else begin
            rcol_q <= rcol_q + COL_W'(1);
          end
        end
      end

      if (state_q == ST_R_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Multiplier and divider datapath.
  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
    if (div_start) begin
      div_r_q <= div_r0_in;
      div_d_q <= div_d_in;
      div_n_q <= div_n_in;
      div_q_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_r_q <= div_ge ? RW'(div_rem2 - {1'b0, div_d_q}) : RW'(div_rem2);
      div_n_q <= {div_n_q[62:0], 1'b0};
      div_q_q <= {div_q_q[62:0], div_ge};
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          red_q   <= s_axis_tdata_i[31:0];
          green_q <= s_axis_tdata_i[63:32];
          blue_q  <= s_axis_tdata_i[95:64];
          err_q   <= !phase_q;
        end
      end
      ST_L_M1: acc_q <= 50'(mul_p_q);
      ST_L_M2: acc_q <= acc_q + 50'(mul_p_q);
      ST_L_M3: begin
        lum_q     <= 32'((acc_q + 50'(mul_p_q) + 50'd32768) >> 16);
        sine_rd_q <= 1'b0;
      end
      ST_L_WT: begin
        if (cfg_eq_q) weight_q <= lum_q;
      end
      ST_L_WT2:   weight_q  <= 32'((mul_p_q + 64'd32768) >> 16);
      ST_L_STORE: row_acc_q <= row_acc_new;
      ST_S_X:     x_q <= x_now;
      ST_S_X2: begin
        x2_q <= x2_now;
        ti_q <= 3'd0;
      end
      ST_S_TM: ti_q <= ti_q + 3'd1;
      ST_S_Q:  sine_q <= (q_sine > 18'd65536) ? 17'd65536 : q_sine[16:0];
      ST_R_LAT: begin
        if (rcol_q == '0) begin
          row_pre_q  <= '0;
          marg_pre_q <= ((rrow_q == '0) ? '0 : marg_pre_q) + GT_W'(rs_rd_q);
          sine_rd_q  <= 1'b1;
        end
      end
      ST_R_SCW: begin
        scale_q <= div_q_q;
        if (gt_q == '0) marg_q <= '0;
      end
      ST_R_MW: marg_q <= 17'(div_q_q + 64'(div_rnd));
      ST_R_COND: begin
        row_pre_q <= rp_new;
        if (rs_rd_q == '0) cond_q <= '0;
      end
      ST_R_CW: cond_q <= 17'(div_q_q + 64'(div_rnd));
      ST_R_PDF: begin
        if (gt_q == '0) pdf_q <= '0;
      end
      ST_R_RW: r32_q <= 33'(div_q_q + 64'(div_rnd));
      ST_R_P2: t2_q  <= 34'(p2_sum >> 32);
      ST_R_P3: pdf_q <= (p3_sum[65:32] != '0) ? 32'hFFFF_FFFF : p3_sum[31:0];
      default: ;
    endcase
  end

  // Weight and row-sum memories.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_L_STORE) begin
      wmem[lpos_q]  <= weight_q;
      rsmem[lrow_q] <= row_acc_new;
    end
    if (state_q == ST_R_RD) begin
      w_rd_q <= wmem[rpos_q];
      if (rcol_q == '0) rs_rd_q <= rsmem[rrow_q];
    end
  end

  // Output register; a finished word waits here while the next word is taken.
  logic [16:0] out_cond_q, out_marg_q;
  logic [31:0] out_pdf_q;
  logic [9:0]  out_col_q;
  logic [8:0]  out_row_q;
  logic        out_last_q, out_status_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_R_OUT && out_free) begin
      if (err_q) begin
        out_cond_q   <= '0;
        out_marg_q   <= '0;
        out_pdf_q    <= '0;
        out_col_q    <= '0;
        out_row_q    <= '0;
        out_last_q   <= 1'b0;
        out_status_q <= STATUS_EARLY;
      end else begin
        out_cond_q   <= cond_q;
        out_marg_q   <= (rcol_q == '0) ? marg_q : 17'd0;
        out_pdf_q    <= pdf_q;
        out_col_q    <= 10'(rcol_q);
        out_row_q    <= 9'(rrow_q);
        out_last_q   <= r_last;
        out_status_q <= STATUS_OK;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_row_q, out_col_q, out_pdf_q, out_marg_q, out_cond_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

`default_nettype wire
